[rtl/source_text_tokenizer_defines.svh]
// assertion macros for the source text tokenizer
`ifndef SOURCE_TEXT_TOKENIZER_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_DEFINES_SVH

// same-cycle implication on clk, off during reset
`define STT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tokenizer assertion failed");

// next-cycle implication on clk, off during reset
`define STT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tokenizer assertion failed");

`endif

[rtl/stt_pkg.sv]
// shared types, token codes and keyword table for the source text tokenizer
package stt_pkg;

	localparam int POS_BITS   = 20;
	localparam int LINE_BITS  = 16;
	localparam int LEN_BITS   = 16;
	localparam int KIND_W     = 6;
	localparam int LINE_W     = 16;
	localparam int POS_W      = 20;
	localparam int LEN_W      = 16;
	localparam int PREFIX_W   = 48;
	localparam int MAX_RES    = 3;
	localparam int FIFO_DEPTH = 4;
	localparam int NUM_KW     = 16;
	localparam int KW_MAX_LEN = 6;

	localparam logic [7:0] CH_CR = 8'h0d;

	localparam logic [KIND_W-1:0] K_LPAREN  = 6'd0;
	localparam logic [KIND_W-1:0] K_RPAREN  = 6'd1;
	localparam logic [KIND_W-1:0] K_LBRACE  = 6'd2;
	localparam logic [KIND_W-1:0] K_RBRACE  = 6'd3;
	localparam logic [KIND_W-1:0] K_COMMA   = 6'd4;
	localparam logic [KIND_W-1:0] K_DOT     = 6'd5;
	localparam logic [KIND_W-1:0] K_MINUS   = 6'd6;
	localparam logic [KIND_W-1:0] K_PLUS    = 6'd7;
	localparam logic [KIND_W-1:0] K_SEMI    = 6'd8;
	localparam logic [KIND_W-1:0] K_SLASH   = 6'd9;
	localparam logic [KIND_W-1:0] K_STAR    = 6'd10;
	localparam logic [KIND_W-1:0] K_BANG    = 6'd11;
	localparam logic [KIND_W-1:0] K_EQUAL   = 6'd13;
	localparam logic [KIND_W-1:0] K_GREATER = 6'd15;
	localparam logic [KIND_W-1:0] K_LESS    = 6'd17;
	localparam logic [KIND_W-1:0] K_IDENT   = 6'd19;
	localparam logic [KIND_W-1:0] K_STRING  = 6'd20;
	localparam logic [KIND_W-1:0] K_NUMBER  = 6'd21;
	localparam logic [KIND_W-1:0] K_AND     = 6'd22;
	localparam logic [KIND_W-1:0] K_EOF     = 6'd38;
	localparam logic [KIND_W-1:0] K_BAD     = 6'd39;
	localparam logic [KIND_W-1:0] K_UNTERM  = 6'd40;

	typedef enum logic [3:0] {
		M_IDLE,
		M_OP2,
		M_SLASH,
		M_COMMENT,
		M_STRING,
		M_INT,
		M_INT_DOT,
		M_FRAC,
		M_IDENT
	} scan_mode_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [LINE_W-1:0] line;
		logic [POS_W-1:0]  start_pos;
		logic [LEN_W-1:0]  length;
		logic              last;
	} result_t;

	typedef struct packed {
		logic [1:0]                cnt;
		result_t [MAX_RES-1:0]     res;
	} step_out_t;

	// keyword text right-aligned, first byte highest
	localparam logic [PREFIX_W-1:0] KW_TEXT [NUM_KW] = '{
		48'h616e64,
		48'h636c617373,
		48'h656c7365,
		48'h66616c7365,
		48'h66756e,
		48'h666f72,
		48'h6966,
		48'h6e696c,
		48'h6f72,
		48'h7072696e74,
		48'h72657475726e,
		48'h7375706572,
		48'h74686973,
		48'h74727565,
		48'h766172,
		48'h7768696c65
	};

	localparam logic [2:0] KW_LEN [NUM_KW] = '{
		3'd3, 3'd5, 3'd4, 3'd5, 3'd3, 3'd3, 3'd2, 3'd3,
		3'd2, 3'd5, 3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd5
	};

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
	endfunction

	function automatic logic [LEN_BITS-1:0] len_inc(input logic [LEN_BITS-1:0] n);
		return (n == '1) ? n : n + 1'b1;
	endfunction

	function automatic logic [KIND_W-1:0] kw_kind(input logic [PREFIX_W-1:0] prefix,
			input logic [LEN_BITS-1:0] n);
		logic [KIND_W-1:0] k;
		k = K_IDENT;
		if (n <= LEN_BITS'(KW_MAX_LEN)) begin
			for (int i = 0; i < NUM_KW; i++) begin
				if ((n == LEN_BITS'(KW_LEN[i])) && (prefix == KW_TEXT[i])) begin
					k = K_AND + KIND_W'(i);
				end
			end
		end
		return k;
	endfunction

endpackage

[rtl/stt_scan_core.sv]
// scanner state registers and the per-byte token decision logic
module stt_scan_core import stt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       cmd,
	input  logic [7:0] ch,
	output step_out_t  res_o
);

	scan_mode_t            mode_q, mode_d;
	logic [KIND_W-1:0]     pend_q, pend_d;
	logic [POS_BITS-1:0]   tstart_q, tstart_d;
	logic [LINE_BITS-1:0]  line_q, line_d;
	logic [POS_BITS-1:0]   pos_q, pos_d;
	logic [LEN_BITS-1:0]   tlen_q, tlen_d;
	logic [PREFIX_W-1:0]   prefix_q, prefix_d;

	function automatic result_t mk(input logic [KIND_W-1:0] k, input logic [POS_BITS-1:0] s,
			input logic [LEN_BITS-1:0] n);
		result_t r;
		r = '0;
		r.kind = k;
		r.start_pos = POS_W'(s);
		r.length = LEN_W'(n);
		return r;
	endfunction

	result_t             fl0, fl1, ex, st_ex;
	logic [1:0]          nf, nf_eff, n;
	logic                nx, st_nx, do_flush, restart;
	scan_mode_t          st_mode;
	logic                st_pend_set, st_prefix_set, st_line_inc;
	logic [KIND_W-1:0]   st_kind, st_pend;
	logic [POS_BITS-1:0] dot_pos;
	logic [LINE_BITS-1:0] line_inc;
	result_t [MAX_RES-1:0] slots;

	assign dot_pos  = (pos_q != '0) ? pos_q - 1'b1 : '0;
	assign line_inc = (line_q == '1) ? line_q : line_q + 1'b1;

	// what the held token gives when it ends
	always_comb begin
		fl0 = '0;
		fl1 = '0;
		nf = 2'd0;
		case (mode_q)
			M_OP2: begin
				fl0 = mk(pend_q, tstart_q, LEN_BITS'(1));
				nf = 2'd1;
			end
			M_SLASH: begin
				fl0 = mk(K_SLASH, tstart_q, LEN_BITS'(1));
				nf = 2'd1;
			end
			M_STRING: begin
				fl0 = mk(K_UNTERM, tstart_q, tlen_q);
				nf = 2'd1;
			end
			M_INT, M_FRAC: begin
				fl0 = mk(K_NUMBER, tstart_q, tlen_q);
				nf = 2'd1;
			end
			M_INT_DOT: begin
				fl0 = mk(K_NUMBER, tstart_q, tlen_q);
				fl1 = mk(K_DOT, dot_pos, LEN_BITS'(1));
				nf = 2'd2;
			end
			M_IDENT: begin
				fl0 = mk(kw_kind(prefix_q, tlen_q), tstart_q, tlen_q);
				nf = 2'd1;
			end
			default: nf = 2'd0;
		endcase
	end

	// what the byte gives when it opens a new token
	always_comb begin
		st_mode = M_IDLE;
		st_nx = 1'b0;
		st_kind = K_BAD;
		st_pend_set = 1'b0;
		st_pend = K_BANG;
		st_prefix_set = 1'b0;
		st_line_inc = 1'b0;
		case (ch)
			"(": begin st_nx = 1'b1; st_kind = K_LPAREN; end
			")": begin st_nx = 1'b1; st_kind = K_RPAREN; end
			"{": begin st_nx = 1'b1; st_kind = K_LBRACE; end
			"}": begin st_nx = 1'b1; st_kind = K_RBRACE; end
			",": begin st_nx = 1'b1; st_kind = K_COMMA; end
			".": begin st_nx = 1'b1; st_kind = K_DOT; end
			"-": begin st_nx = 1'b1; st_kind = K_MINUS; end
			"+": begin st_nx = 1'b1; st_kind = K_PLUS; end
			";": begin st_nx = 1'b1; st_kind = K_SEMI; end
			"*": begin st_nx = 1'b1; st_kind = K_STAR; end
			"!": begin st_pend_set = 1'b1; st_pend = K_BANG; st_mode = M_OP2; end
			"=": begin st_pend_set = 1'b1; st_pend = K_EQUAL; st_mode = M_OP2; end
			">": begin st_pend_set = 1'b1; st_pend = K_GREATER; st_mode = M_OP2; end
			"<": begin st_pend_set = 1'b1; st_pend = K_LESS; st_mode = M_OP2; end
			"/": st_mode = M_SLASH;
			" ", CH_CR, "\t": st_mode = M_IDLE;
			"\n": st_line_inc = 1'b1;
			"\"": st_mode = M_STRING;
			default: begin
				if (is_digit(ch)) begin
					st_mode = M_INT;
				end else if (is_alpha(ch)) begin
					st_mode = M_IDENT;
					st_prefix_set = 1'b1;
				end else begin
					st_nx = 1'b1;
					st_kind = K_BAD;
				end
			end
		endcase
		st_ex = mk(st_kind, pos_q, LEN_BITS'(1));
	end

	always_comb begin
		mode_d = mode_q;
		pend_d = pend_q;
		tstart_d = tstart_q;
		line_d = line_q;
		pos_d = pos_q;
		tlen_d = tlen_q;
		prefix_d = prefix_q;
		do_flush = 1'b0;
		restart = 1'b0;
		ex = '0;
		nx = 1'b0;
		if (cmd) begin
			do_flush = 1'b1;
			ex = mk(K_EOF, pos_q, '0);
			nx = 1'b1;
			mode_d = M_IDLE;
		end else begin
			case (mode_q)
				M_OP2: begin
					if (ch == "=") begin
						ex = mk(pend_q + 1'b1, tstart_q, LEN_BITS'(2));
						nx = 1'b1;
						mode_d = M_IDLE;
					end else begin
						do_flush = 1'b1;
						restart = 1'b1;
					end
				end
				M_SLASH: begin
					if (ch == "/") begin
						mode_d = M_COMMENT;
					end else begin
						do_flush = 1'b1;
						restart = 1'b1;
					end
				end
				M_COMMENT: begin
					if (ch == "\n") restart = 1'b1;
				end
				M_STRING: begin
					tlen_d = len_inc(tlen_q);
					if (ch == "\n") line_d = line_inc;
					if (ch == "\"") begin
						ex = mk(K_STRING, tstart_q, len_inc(tlen_q));
						nx = 1'b1;
						mode_d = M_IDLE;
					end
				end
				M_INT: begin
					if (is_digit(ch)) begin
						tlen_d = len_inc(tlen_q);
					end else if (ch == ".") begin
						mode_d = M_INT_DOT;
					end else begin
						do_flush = 1'b1;
						restart = 1'b1;
					end
				end
				M_INT_DOT: begin
					if (is_digit(ch)) begin
						tlen_d = len_inc(len_inc(tlen_q));
						mode_d = M_FRAC;
					end else begin
						do_flush = 1'b1;
						restart = 1'b1;
					end
				end
				M_FRAC: begin
					if (is_digit(ch)) begin
						tlen_d = len_inc(tlen_q);
					end else begin
						do_flush = 1'b1;
						restart = 1'b1;
					end
				end
				M_IDENT: begin
					if (is_alpha(ch) || is_digit(ch)) begin
						if (tlen_q < LEN_BITS'(KW_MAX_LEN)) begin
							prefix_d = {prefix_q[PREFIX_W-9:0], ch};
						end
						tlen_d = len_inc(tlen_q);
					end else begin
						do_flush = 1'b1;
						restart = 1'b1;
					end
				end
				default: restart = 1'b1;
			endcase
			if (restart) begin
				tstart_d = pos_q;
				tlen_d = LEN_BITS'(1);
				mode_d = st_mode;
				if (st_pend_set) pend_d = st_pend;
				if (st_prefix_set) prefix_d = PREFIX_W'(ch);
				if (st_line_inc) line_d = line_inc;
				ex = st_ex;
				nx = st_nx;
			end
			pos_d = (pos_q == '1) ? pos_q : pos_q + 1'b1;
		end
	end

	// pack flush tokens first, then the byte's own token
	always_comb begin
		nf_eff = do_flush ? nf : 2'd0;
		n = nf_eff + {1'b0, nx};
		slots[0] = (nf_eff != 2'd0) ? fl0 : ex;
		slots[1] = (nf_eff == 2'd2) ? fl1 : ex;
		slots[2] = ex;
		for (int i = 0; i < MAX_RES; i++) begin
			slots[i].line = LINE_W'(line_q);
			slots[i].last = (2'(i + 1) == n);
		end
		res_o.res = slots;
		res_o.cnt = step ? n : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			pend_q <= '0;
			tstart_q <= '0;
			line_q <= LINE_BITS'(1);
			pos_q <= '0;
			tlen_q <= '0;
			prefix_q <= '0;
		end else if (step) begin
			mode_q <= mode_d;
			pend_q <= pend_d;
			tstart_q <= tstart_d;
			line_q <= line_d;
			pos_q <= pos_d;
			tlen_q <= tlen_d;
			prefix_q <= prefix_d;
		end
	end

endmodule

[rtl/stt_result_fifo.sv]
// small token queue taking up to three tokens a cycle and handing out one while m_ready is high
`include "source_text_tokenizer_defines.svh"

module stt_result_fifo import stt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  step_out_t push,
	output logic      space_ok,
	output logic      m_valid,
	input  logic      m_ready,
	output result_t   m_data
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	result_t            mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_q, rd_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               pop;

	assign m_valid  = (cnt_q != '0);
	assign m_data   = mem_q[rd_q];
	assign pop      = m_valid && m_ready;
	assign space_ok = (cnt_q <= CNT_W'(FIFO_DEPTH - MAX_RES));

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++) begin
			if (2'(i) < push.cnt) mem_q[wr_q + PTR_W'(i)] <= push.res[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + PTR_W'(push.cnt);
			rd_q <= rd_q + PTR_W'(pop);
			cnt_q <= cnt_q + CNT_W'(push.cnt) - CNT_W'(pop);
		end
	end

	`STT_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(FIFO_DEPTH))
	`STT_ASSERT_NOW(a_push_room, push.cnt != 2'd0, space_ok)
	`STT_ASSERT_NEXT(a_cnt_track, 1'b1, cnt_q == $past(cnt_q) + CNT_W'($past(push.cnt)) - CNT_W'($past(pop)))

endmodule

[rtl/source_text_tokenizer.sv]
// top level of the source text tokenizer: input register, scanner and token queue
//
//   channel   dir  tdata                                      tuser     tlast
//   s_*       in   ch[7:0]                                    cmd       -
//   m_*       out  line[15:0] start_pos[35:16] length[51:36]  kind[5:0] last
//
// one input beat per cycle while m_tready is high and each byte yields at most one token
// a beat is scanned only while the four-entry token queue holds at most one
// token, so a beat yielding two or three tokens stalls the next until the queue drains
// an input beat passes through the input register and then the token queue before its first token
// reset sets all scanner state at once (line number to 1, the rest to zero), no clearing pass
// m_tready low fills the queue and then drops s_tready
module source_text_tokenizer import stt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // ch
	input  logic        s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // line, start_pos, length, zero pad
	output logic [5:0]  m_tuser,   // kind
	output logic        m_tlast
);

	logic       v_s1;
	logic       cmd_s1;
	logic [7:0] ch_s1;
	logic       accept_in, proc, space_ok;
	step_out_t  step_res;
	result_t    head;

	assign proc      = v_s1 && space_ok;
	assign s_tready  = !v_s1 || proc;
	assign accept_in = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept_in) begin
			v_s1 <= 1'b1;
		end else if (proc) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			cmd_s1 <= s_tuser;
			ch_s1 <= s_tdata;
		end
	end

	stt_scan_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (proc),
		.cmd    (cmd_s1),
		.ch     (ch_s1),
		.res_o  (step_res)
	);

	stt_result_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (step_res),
		.space_ok (space_ok),
		.m_valid  (m_tvalid),
		.m_ready  (m_tready),
		.m_data   (head)
	);

	assign m_tdata = {4'b0, head.length, head.start_pos, head.line};
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

endmodule

[bench/source_text_tokenizer_test.sv]
// testbench for source_text_tokenizer: directed and random source text checked against a token predictor
module source_text_tokenizer_test;
	import stt_pkg::*;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_END  = 1'b1;

	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0a;
	localparam logic [7:0] CH_CR  = 8'h0d;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int          TAIL_CYCLES = 10;
	localparam int          ITEM_GOAL   = 215;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;
	logic [5:0]  m_tuser;
	logic        m_tlast;

	source_text_tokenizer uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #5 clk = ~clk;

	string kw_list [16] = '{"and", "class", "else", "false", "fun", "for", "if", "nil",
		"or", "print", "return", "super", "this", "true", "var", "while"};
	string op_list [19] = '{"(", ")", "{", "}", ",", ".", "-", "+", ";", "*", "/",
		"!", "!=", "=", "==", "<", "<=", ">", ">="};

	// scanner state mirrored by the predictor
	scan_mode_t          mode;
	logic [KIND_W-1:0]   pend_kind;
	logic [POS_W-1:0]    tok_start;
	logic [LINE_W-1:0]   line_no;
	logic [POS_W-1:0]    pos;
	logic [LEN_W-1:0]    tok_len;
	logic [PREFIX_W-1:0] prefix;

	result_t beat_tokens [$];
	result_t tokens_due [$];

	int errors = 0;
	int beats_sent = 0;
	int tx_calm = 0;
	int rx_calm = 0;
	int unsigned cycles = 0;

	function automatic void add_token(logic [KIND_W-1:0] k, logic [POS_W-1:0] s,
			logic [LEN_W-1:0] n);
		result_t r;
		r.kind = k;
		r.line = line_no;
		r.start_pos = s;
		r.length = n;
		r.last = 1'b0;
		if (beat_tokens.size() < MAX_RES) beat_tokens.insert(beat_tokens.size(), r);
	endfunction

	function automatic logic digit_ch(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic letter_ch(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic void bump_len();
		if (tok_len != '1) tok_len++;
	endfunction

	function automatic logic [KIND_W-1:0] word_token();
		logic [PREFIX_W-1:0] text;
		logic [KIND_W-1:0] k;
		k = K_IDENT;
		if (tok_len <= 6) begin
			for (int i = 0; i < 16; i++) begin
				text = '0;
				for (int j = 0; j < kw_list[i].len(); j++) text = {text[39:0], kw_list[i][j]};
				if (tok_len == kw_list[i].len() && prefix == text) k = K_AND + KIND_W'(i);
			end
		end
		return k;
	endfunction

	function automatic void close_pending(logic [POS_W-1:0] p);
		case (mode)
			M_OP2: add_token(pend_kind, tok_start, 1);
			M_SLASH: add_token(K_SLASH, tok_start, 1);
			M_STRING: add_token(K_UNTERM, tok_start, tok_len);
			M_INT, M_FRAC: add_token(K_NUMBER, tok_start, tok_len);
			M_INT_DOT: begin
				add_token(K_NUMBER, tok_start, tok_len);
				add_token(K_DOT, (p != 0) ? p - 1'b1 : '0, 1);
			end
			M_IDENT: add_token(word_token(), tok_start, tok_len);
			default: ;
		endcase
		mode = M_IDLE;
	endfunction

	function automatic void begin_token(logic [7:0] c, logic [POS_W-1:0] p);
		tok_start = p;
		tok_len = 1;
		mode = M_IDLE;
		case (c)
			"(": add_token(K_LPAREN, p, 1);
			")": add_token(K_RPAREN, p, 1);
			"{": add_token(K_LBRACE, p, 1);
			"}": add_token(K_RBRACE, p, 1);
			",": add_token(K_COMMA, p, 1);
			".": add_token(K_DOT, p, 1);
			"-": add_token(K_MINUS, p, 1);
			"+": add_token(K_PLUS, p, 1);
			";": add_token(K_SEMI, p, 1);
			"*": add_token(K_STAR, p, 1);
			"!": begin
				pend_kind = K_BANG;
				mode = M_OP2;
			end
			"=": begin
				pend_kind = K_EQUAL;
				mode = M_OP2;
			end
			">": begin
				pend_kind = K_GREATER;
				mode = M_OP2;
			end
			"<": begin
				pend_kind = K_LESS;
				mode = M_OP2;
			end
			"/": mode = M_SLASH;
			" ", CH_CR, CH_TAB: ;
			CH_LF: if (line_no != '1) line_no++;
			"\"": mode = M_STRING;
			default: begin
				if (digit_ch(c)) begin
					mode = M_INT;
				end else if (letter_ch(c)) begin
					prefix = {40'd0, c};
					mode = M_IDENT;
				end else begin
					add_token(K_BAD, p, 1);
				end
			end
		endcase
	endfunction

	// tokens caused by one accepted beat, appended to tokens_due
	function automatic void lex_beat(logic cmd, logic [7:0] c);
		logic [POS_W-1:0] p;
		logic restart;
		result_t r;
		beat_tokens.delete();
		p = pos;
		restart = 1'b0;
		if (cmd == CMD_END) begin
			if (mode == M_COMMENT) mode = M_IDLE;
			close_pending(p);
			add_token(K_EOF, p, 0);
		end else begin
			case (mode)
				M_OP2: begin
					if (c == "=") begin
						add_token(pend_kind + 1'b1, tok_start, 2);
						mode = M_IDLE;
					end else begin
						close_pending(p);
						restart = 1'b1;
					end
				end
				M_SLASH: begin
					if (c == "/") begin
						mode = M_COMMENT;
					end else begin
						close_pending(p);
						restart = 1'b1;
					end
				end
				M_COMMENT: begin
					if (c == CH_LF) begin
						mode = M_IDLE;
						restart = 1'b1;
					end
				end
				M_STRING: begin
					bump_len();
					if (c == CH_LF && line_no != '1) line_no++;
					if (c == "\"") begin
						add_token(K_STRING, tok_start, tok_len);
						mode = M_IDLE;
					end
				end
				M_INT: begin
					if (digit_ch(c)) begin
						bump_len();
					end else if (c == ".") begin
						mode = M_INT_DOT;
					end else begin
						close_pending(p);
						restart = 1'b1;
					end
				end
				M_INT_DOT: begin
					if (digit_ch(c)) begin
						bump_len();
						bump_len();
						mode = M_FRAC;
					end else begin
						close_pending(p);
						restart = 1'b1;
					end
				end
				M_FRAC: begin
					if (digit_ch(c)) begin
						bump_len();
					end else begin
						close_pending(p);
						restart = 1'b1;
					end
				end
				M_IDENT: begin
					if (letter_ch(c) || digit_ch(c)) begin
						if (tok_len < 6) prefix = {prefix[39:0], c};
						bump_len();
					end else begin
						close_pending(p);
						restart = 1'b1;
					end
				end
				default: restart = 1'b1;
			endcase
			if (restart) begin_token(c, p);
			if (pos != '1) pos++;
		end
		for (int i = 0; i < beat_tokens.size(); i++) begin
			r = beat_tokens[i];
			r.last = (i == beat_tokens.size() - 1);
			tokens_due.insert(tokens_due.size(), r);
		end
	endfunction

	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 9) == 0) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 19);
	endfunction

	function automatic logic [7:0] word_char();
		int r;
		r = $urandom_range(0, 62);
		if (r < 26) return 8'("a" + r);
		if (r < 52) return 8'("A" + r - 26);
		if (r < 62) return 8'("0" + r - 52);
		return "_";
	endfunction

	task automatic send_beat(input logic cmd, input logic [7:0] c);
		int gap;
		gap = draw_wait(tx_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= c;
		do @(posedge clk); while (!s_tready);
		lex_beat(cmd, c);
		beats_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_beat(CMD_BYTE, s[i]);
	endtask

	task automatic send_end();
		send_beat(CMD_END, 8'($urandom_range(0, 255)));
	endtask

	task automatic wait_quiet();
		s_tvalid <= 1'b0;
		while (tokens_due.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic check_token();
		result_t want;
		if (tokens_due.size() == 0) begin
			$error("token with nothing expected: kind %0d", m_tuser);
			errors++;
		end else begin
			want = tokens_due.pop_front();
			if (m_tuser !== want.kind) begin
				$error("kind: expected %0d, got %0d", want.kind, m_tuser);
				errors++;
			end
			if (m_tdata[15:0] !== want.line) begin
				$error("line: expected %0d, got %0d", want.line, m_tdata[15:0]);
				errors++;
			end
			if (m_tdata[35:16] !== want.start_pos) begin
				$error("start_pos: expected %0d, got %0d", want.start_pos, m_tdata[35:16]);
				errors++;
			end
			if (m_tdata[51:36] !== want.length) begin
				$error("length: expected %0d, got %0d", want.length, m_tdata[51:36]);
				errors++;
			end
			if (m_tlast !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, m_tlast);
				errors++;
			end
		end
	endtask

	task automatic test_single_ops();
		send_text("(){},.-+;*");
		send_beat(CMD_BYTE, " ");
		send_beat(CMD_BYTE, CH_TAB);
		send_beat(CMD_BYTE, CH_CR);
		send_beat(CMD_BYTE, CH_LF);
		send_beat(CMD_BYTE, 8'h00);
		send_beat(CMD_BYTE, 8'hff);
		send_beat(CMD_BYTE, 8'h80);
		send_text("@#");
	endtask

	task automatic test_compare_ops();
		send_text("!!=x= ==<<=>>= <");
		send_end();
	endtask

	task automatic test_slash_comment();
		send_text("a/b//c\n/");
		send_end();
		send_text("//z");
		send_end();
	endtask

	task automatic test_strings();
		send_text("\"a\nb\"\"open");
		send_end();
	endtask

	task automatic test_numbers();
		// dot after digits then a non-digit gives number, dot and the next token
		send_text("12.5 7;3.x 9..1 4.");
		send_end();
	endtask

	task automatic test_words();
		send_text("if orchid o returned superb _Z9");
		send_end();
	endtask

	task automatic test_random_text();
		int goal;
		int n;
		goal = ITEM_GOAL;
		while (beats_sent < goal) begin
			case ($urandom_range(0, 13))
				0, 1: send_text(kw_list[$urandom_range(0, 15)]);
				2: begin
					n = $urandom_range(0, 8);
					send_beat(CMD_BYTE, (word_char() <= "9") ? "_" : word_char());
					repeat (n) send_beat(CMD_BYTE, word_char());
				end
				3: begin
					repeat ($urandom_range(1, 4)) send_beat(CMD_BYTE, 8'("0" + $urandom_range(0, 9)));
					case ($urandom_range(0, 3))
						0: ;
						1: begin
							send_beat(CMD_BYTE, ".");
							repeat ($urandom_range(1, 3))
								send_beat(CMD_BYTE, 8'("0" + $urandom_range(0, 9)));
						end
						2: send_beat(CMD_BYTE, ".");
						default: send_text("..");
					endcase
				end
				4: begin
					send_beat(CMD_BYTE, "\"");
					repeat ($urandom_range(0, 6))
						send_beat(CMD_BYTE, ($urandom_range(0, 4) == 0) ? CH_LF : word_char());
					if ($urandom_range(0, 7) == 0) send_end();
					else send_beat(CMD_BYTE, "\"");
				end
				5, 6, 7: send_text(op_list[$urandom_range(0, 18)]);
				8: begin
					send_text("//");
					repeat ($urandom_range(0, 4)) send_beat(CMD_BYTE, word_char());
					if ($urandom_range(0, 4) == 0) send_end();
					else send_beat(CMD_BYTE, CH_LF);
				end
				9: begin
					case ($urandom_range(0, 3))
						0: send_beat(CMD_BYTE, " ");
						1: send_beat(CMD_BYTE, CH_TAB);
						2: send_beat(CMD_BYTE, CH_CR);
						default: send_beat(CMD_BYTE, CH_LF);
					endcase
				end
				10, 11: send_beat(CMD_BYTE, 8'($urandom_range(0, 255)));
				default: send_end();
			endcase
			if ($urandom_range(0, 1) == 0) send_beat(CMD_BYTE, " ");
		end
		send_end();
	endtask

	// result side: random stalls, every beat checked
	initial begin
		int stall;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = draw_wait(rx_calm);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			check_token();
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= CMD_BYTE;
		mode = M_IDLE;
		pend_kind = '0;
		tok_start = '0;
		line_no = 1;
		pos = '0;
		tok_len = '0;
		prefix = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_ops();
		test_compare_ops();
		test_slash_comment();
		test_strings();
		test_numbers();
		test_words();
		wait_quiet();
		test_random_text();
		wait_quiet();
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
